### sv/ntge_pkg.sv
// Shared types and constants for the neighbor table with gap average.
package ntge_pkg;

	// Result status codes.
	localparam logic [1:0] STATUS_UPDATED = 2'd0;
	localparam logic [1:0] STATUS_ADDED   = 2'd1;
	localparam logic [1:0] STATUS_DROPPED = 2'd2;

	// Unity in 8.8 fixed point and the reset weight of a new gap.
	localparam logic [15:0] EWMA_UNITY  = 16'h0100;
	localparam logic [8:0]  ALPHA_RESET = 9'h040;

	// Entry payload word: seqno, average, rssi, lqi from the lowest bit up.
	localparam int unsigned DATA_W = 56;

	// Request to the average update unit.
	typedef struct packed {
		logic [7:0]  seqno;
		logic [7:0]  prev_seqno;
		logic [15:0] avg;
	} ntge_ewma_req_t;

	// Answer of the average update unit.
	typedef struct packed {
		logic        done;
		logic [7:0]  gap;
		logic [15:0] avg;
	} ntge_ewma_rsp_t;

	// One result item before it goes to the output register.
	typedef struct packed {
		logic [1:0]  status;
		logic [3:0]  entry_index;
		logic [7:0]  gap;
		logic [15:0] avg_gap;
	} ntge_result_t;

endpackage

### sv/ntge_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module ntge_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port, registered.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### sv/ntge_ewma.sv
// Two-stage unit that computes the sequence gap and the updated 8.8 average.
module ntge_ewma import ntge_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  ntge_ewma_req_t req,
	input  logic [8:0]     alpha,
	output ntge_ewma_rsp_t rsp
);

	logic [8:0]  alpha_eff;
	logic [7:0]  alpha_inv;
	logic [7:0]  gap_c;
	logic        vld_s1;
	logic [7:0]  gap_s1;
	logic [16:0] prod_gap_s1;
	logic [23:0] prod_avg_s1;
	logic [17:0] sum_c;
	logic        vld_s2;
	logic [7:0]  gap_s2;
	logic [15:0] avg_s2;

	// Clamp the weight to 1..256; the old average keeps 256 minus that.
	always_comb begin
		if (alpha == 9'd0) begin
			alpha_eff = 9'd1;
		end else if (alpha > {1'b0, EWMA_UNITY[7:0]} + 9'd256) begin
			alpha_eff = 9'd256;
		end else if (alpha > 9'd256) begin
			alpha_eff = 9'd256;
		end else begin
			alpha_eff = alpha;
		end
		alpha_inv = 8'(9'd256 - alpha_eff);
		gap_c     = req.seqno - req.prev_seqno;
	end

	// Stage 1: both products.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			gap_s1      <= gap_c;
			prod_gap_s1 <= {9'd0, gap_c} * {8'd0, alpha_eff};
			prod_avg_s1 <= {8'd0, req.avg} * {16'd0, alpha_inv};
		end
	end

	// Stage 2: add the scaled old average and saturate to 16 bits.
	assign sum_c = {1'b0, prod_gap_s1} + {2'd0, prod_avg_s1[23:8]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			gap_s2 <= gap_s1;
			avg_s2 <= (sum_c > 18'h0FFFF) ? 16'hFFFF : sum_c[15:0];
		end
	end

	assign rsp.done = vld_s2;
	assign rsp.gap  = gap_s2;
	assign rsp.avg  = avg_s2;

endmodule

### sv/neighbor_table_seqno_gap_ewma.sv
// Top level: neighbor table search, entry append and gap average update.
//
// Each input item on the s_ channel is one received beacon. The block looks
// up the sender address by reading the address memory one slot a cycle,
// lowest slot first, and stops at the first match. An unknown sender is
// appended if a slot is free; otherwise the beacon is dropped. Exactly one
// result item per beacon leaves on the m_ channel.
// One item is worked on at a time. The sequencer returns to idle as the
// result is loaded, and only then takes the next item; the address scan,
// one memory read per cycle, makes the time per item grow with the count.
// The result sits in an output register, so the next beacon is accepted
// while a finished result still waits for m_tready. When the receiver
// stalls with a second result ready, the sequencer holds until the output
// register frees up, and s_tready stays low meanwhile. Reset clears the
// entry count and sets the weight register to 64; the memories are not
// cleared, as only slots below the count are ever read. The weight register
// is written through cfg_wr_en/cfg_wr_data; the user must do so only while
// idle, as the block itself does not enforce this.
module neighbor_table_seqno_gap_ewma import ntge_pkg::*; #(
	parameter int unsigned TABLE_ENTRIES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// Beacon items.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,   // sender_addr[15:0], beacon_seqno[23:16], rssi[39:24], lqi[55:40]
	// Result items.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // status[1:0], entry_index[5:2], gap[13:6], avg_gap[29:14]
	// Weight register.
	input  logic        cfg_wr_en,
	input  logic [8:0]  cfg_wr_data
);

	localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SCAN  = 3'd1;
	localparam logic [2:0] ST_FETCH = 3'd2;
	localparam logic [2:0] ST_MUL   = 3'd3;
	localparam logic [2:0] ST_WAIT  = 3'd4;
	localparam logic [2:0] ST_OUT   = 3'd5;

	logic [2:0]        state_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  scan_cnt_q;
	logic              rd_pend_s1;
	logic [IDX_W-1:0]  rd_idx_s1;
	logic [IDX_W-1:0]  slot_q;
	logic [15:0]       addr_q;
	logic [7:0]        seq_q;
	logic [15:0]       rssi_q;
	logic [15:0]       lqi_q;
	logic [8:0]        alpha_q;
	ntge_result_t      res_q;
	logic              m_tvalid_q;
	logic [31:0]       m_tdata_q;

	logic              in_acc;
	logic              hit;
	logic              issue;
	logic              miss_done;
	logic              full;
	logic              out_free;
	logic              addr_we;
	logic [15:0]       addr_rdata;
	logic              data_we;
	logic [IDX_W-1:0]  data_waddr;
	logic [DATA_W-1:0] data_wdata;
	logic [DATA_W-1:0] data_rdata;
	ntge_ewma_req_t    ewma_req;
	ntge_ewma_rsp_t    ewma_rsp;
	logic              ewma_done;
	logic [IDX_W+3:0]  cnt_idx_ext;
	logic [IDX_W+3:0]  slot_idx_ext;

	assign in_acc   = s_tvalid && s_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign out_free = !m_tvalid_q || m_tready;
	assign full     = (count_q == CNT_W'(TABLE_ENTRIES));

	// Scan control: compare the returning address, issue the next read.
	assign hit       = rd_pend_s1 && (addr_rdata == addr_q);
	assign issue     = (state_q == ST_SCAN) && (scan_cnt_q < count_q) && !hit;
	assign miss_done = (state_q == ST_SCAN) && !hit && !issue && !rd_pend_s1;
	assign addr_we   = miss_done && !full;
	assign ewma_done = (state_q == ST_WAIT) && ewma_rsp.done;

	// Slot numbers as 4-bit result fields.
	assign cnt_idx_ext  = {4'd0, count_q[IDX_W-1:0]};
	assign slot_idx_ext = {4'd0, slot_q};

	// Entry payload write: a fresh entry, or the write-back after an update.
	always_comb begin
		data_we    = addr_we || ewma_done;
		data_waddr = addr_we ? count_q[IDX_W-1:0] : slot_q;
		data_wdata = addr_we ? {lqi_q, rssi_q, EWMA_UNITY, seq_q}
		                     : {lqi_q, rssi_q, ewma_rsp.avg, seq_q};
	end

	assign ewma_req.seqno      = seq_q;
	assign ewma_req.prev_seqno = data_rdata[7:0];
	assign ewma_req.avg        = data_rdata[23:8];

	ntge_ram #(
		.WIDTH (16),
		.DEPTH (TABLE_ENTRIES)
	) u_addr_ram (
		.clk   (clk),
		.we    (addr_we),
		.waddr (count_q[IDX_W-1:0]),
		.wdata (addr_q),
		.re    (issue),
		.raddr (scan_cnt_q[IDX_W-1:0]),
		.rdata (addr_rdata)
	);

	ntge_ram #(
		.WIDTH (DATA_W),
		.DEPTH (TABLE_ENTRIES)
	) u_data_ram (
		.clk   (clk),
		.we    (data_we),
		.waddr (data_waddr),
		.wdata (data_wdata),
		.re    (state_q == ST_FETCH),
		.raddr (slot_q),
		.rdata (data_rdata)
	);

	ntge_ewma u_ewma (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == ST_MUL),
		.req    (ewma_req),
		.alpha  (alpha_q),
		.rsp    (ewma_rsp)
	);

	// Weight register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= ALPHA_RESET;
		end else if (cfg_wr_en) begin
			alpha_q <= cfg_wr_data;
		end
	end

	// Sequencer and entry count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= '0;
			scan_cnt_q <= '0;
			rd_pend_s1 <= 1'b0;
		end else begin
			rd_pend_s1 <= issue;
			unique case (state_q)
				ST_IDLE: begin
					scan_cnt_q <= '0;
					if (in_acc) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (issue) begin
						scan_cnt_q <= scan_cnt_q + CNT_W'(1);
					end
					if (hit) begin
						state_q <= ST_FETCH;
					end else if (miss_done) begin
						if (!full) begin
							count_q <= count_q + CNT_W'(1);
						end
						state_q <= ST_OUT;
					end
				end
				ST_FETCH: begin
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (ewma_rsp.done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Item payload, matched slot and the pending result.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			addr_q <= s_tdata[15:0];
			seq_q  <= s_tdata[23:16];
			rssi_q <= s_tdata[39:24];
			lqi_q  <= s_tdata[55:40];
		end
		rd_idx_s1 <= scan_cnt_q[IDX_W-1:0];
		if (hit) begin
			slot_q <= rd_idx_s1;
		end
		if (miss_done) begin
			if (full) begin
				res_q <= '{status: STATUS_DROPPED, entry_index: 4'd0,
				           gap: 8'd0, avg_gap: 16'd0};
			end else begin
				res_q <= '{status: STATUS_ADDED, entry_index: cnt_idx_ext[3:0],
				           gap: 8'd1, avg_gap: EWMA_UNITY};
			end
		end else if (ewma_done) begin
			res_q <= '{status: STATUS_UPDATED, entry_index: slot_idx_ext[3:0],
			           gap: ewma_rsp.gap, avg_gap: ewma_rsp.avg};
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if ((state_q == ST_OUT) && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_OUT) && out_free) begin
			m_tdata_q <= {2'd0, res_q.avg_gap, res_q.gap, res_q.entry_index, res_q.status};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// The entry count never passes the table size.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(TABLE_ENTRIES))
		else $error("entry count beyond table size");

	// A new address is only written while a slot is free.
	a_append_free: assert property (@(posedge clk) disable iff (!arst_n)
		addr_we |-> (count_q < CNT_W'(TABLE_ENTRIES)))
		else $error("append into a full table");

	// The update unit answers only while the sequencer waits for it.
	a_ewma_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		ewma_rsp.done |-> (state_q == ST_WAIT))
		else $error("average update outside its wait state");

	// An accepted beacon starts the address scan.
	a_accept_scan: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (state_q == ST_SCAN))
		else $error("accepted beacon did not start a scan");

	// A result appears only after the sequencer delivered it.
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> ($past(state_q) == ST_OUT))
		else $error("result without a finished beacon");

endmodule

### verif/neighbor_table_seqno_gap_ewma_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the neighbor table with gap average.
module neighbor_table_seqno_gap_ewma_tb import ntge_pkg::*; ();

	localparam int unsigned TABLE_ENTRIES = 16;
	localparam int unsigned PHASES = 7;
	localparam int unsigned ITEMS_PER_PHASE = 83;
	localparam int unsigned STALL_LIMIT = 3000;
	localparam int unsigned SETTLE_CYCLES = 30;

	// One directed beacon, with a typed-in result where it is obvious.
	typedef struct {
		logic [15:0]  addr;
		logic [7:0]   seqno;
		logic [15:0]  rssi;
		logic [15:0]  lqi;
		bit           typed;
		ntge_result_t want;
	} beacon_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [55:0] s_tdata = '0;   // sender_addr[15:0], beacon_seqno[23:16], rssi[39:24], lqi[55:40]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;        // status[1:0], entry_index[5:2], gap[13:6], avg_gap[29:14]
	logic        cfg_wr_en = 1'b0;
	logic [8:0]  cfg_wr_data = '0;

	// Shadow of the neighbor table and of the weight register.
	logic [15:0] nbr_addr [TABLE_ENTRIES];
	logic [7:0]  nbr_last_seq [TABLE_ENTRIES];
	logic [15:0] nbr_avg [TABLE_ENTRIES];
	int unsigned nbr_count = 0;
	logic [8:0]  alpha_reg = ALPHA_RESET;

	ntge_result_t expected_results[$];
	int unsigned  mismatches = 0;
	int unsigned  beacons_sent = 0;
	int unsigned  n_added = 0;
	int unsigned  n_updated = 0;
	int unsigned  n_dropped = 0;
	int unsigned  tx_idle_pct = 0;
	int unsigned  rx_idle_pct = 0;
	int unsigned  rx_taken = 0;
	int unsigned  hold_left = 0;
	bit           hold_done = 1'b0;
	int unsigned  quiet_cycles = 0;

	// Directed beacons; the weight is at its reset value of 64 here.
	beacon_row_t directed_rows [22] = '{
		'{16'h0000, 8'h00, 16'h0000, 16'h0000, 1'b1, '{STATUS_ADDED,   4'd0, 8'd1,   16'd256}},
		'{16'hFFFF, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b1, '{STATUS_ADDED,   4'd1, 8'd1,   16'd256}},
		'{16'h0000, 8'h00, 16'h1234, 16'hABCD, 1'b1, '{STATUS_UPDATED, 4'd0, 8'd0,   16'd192}},
		'{16'hFFFF, 8'hFE, 16'h0000, 16'hFFFF, 1'b1, '{STATUS_UPDATED, 4'd1, 8'd255, 16'd16512}},
		'{16'h0001, 8'h11, 16'h0101, 16'h8000, 1'b0, '0},
		'{16'h0002, 8'h22, 16'h0202, 16'h4000, 1'b0, '0},
		'{16'h0004, 8'h33, 16'h0404, 16'h2000, 1'b0, '0},
		'{16'h0008, 8'h44, 16'h0808, 16'h1000, 1'b0, '0},
		'{16'h0010, 8'h55, 16'h1010, 16'h0800, 1'b0, '0},
		'{16'h0020, 8'h66, 16'h2020, 16'h0400, 1'b0, '0},
		'{16'h0040, 8'h77, 16'h4040, 16'h0200, 1'b0, '0},
		'{16'h0080, 8'h88, 16'h8080, 16'h0100, 1'b0, '0},
		'{16'h0100, 8'h99, 16'h5555, 16'h0080, 1'b0, '0},
		'{16'h0200, 8'hAA, 16'hAAAA, 16'h0040, 1'b0, '0},
		'{16'h0400, 8'hBB, 16'h3333, 16'h0020, 1'b0, '0},
		'{16'h0800, 8'hCC, 16'hCCCC, 16'h0010, 1'b0, '0},
		'{16'h1000, 8'hDD, 16'h0F0F, 16'h0008, 1'b0, '0},
		'{16'h2000, 8'hEE, 16'hF0F0, 16'h0004, 1'b0, '0},
		'{16'h8000, 8'h10, 16'h5555, 16'hAAAA, 1'b1, '{STATUS_DROPPED, 4'd0, 8'd0,   16'd0}},
		'{16'h4000, 8'h00, 16'hFFFF, 16'h0000, 1'b1, '{STATUS_DROPPED, 4'd0, 8'd0,   16'd0}},
		'{16'h2000, 8'hF0, 16'h0001, 16'h0002, 1'b0, '0},
		'{16'h0000, 8'h01, 16'h7FFF, 16'hFFFE, 1'b0, '0}
	};

	neighbor_table_seqno_gap_ewma #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	// Clock with an 8 ns period.
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Table lookup, append and average update for one accepted beacon.
	function automatic ntge_result_t predict_link_update(input logic [15:0] addr,
			input logic [7:0] seqno);
		ntge_result_t res;
		int unsigned  slot;
		int unsigned  weight;
		int unsigned  avg;
		logic [7:0]   gap;
		bit           hit;
		res = '0;
		slot = 0;
		hit = 1'b0;
		for (int i = 0; i < nbr_count; i++) begin
			if (!hit && nbr_addr[i] == addr) begin
				slot = i;
				hit = 1'b1;
			end
		end
		if (hit) begin
			res.status = STATUS_UPDATED;
		end else if (nbr_count >= TABLE_ENTRIES) begin
			// A full table drops the beacon and leaves the state alone.
			res.status = STATUS_DROPPED;
			return res;
		end else begin
			slot = nbr_count;
			nbr_count++;
			nbr_addr[slot] = addr;
			nbr_last_seq[slot] = seqno - 8'd1;
			nbr_avg[slot] = EWMA_UNITY;
			res.status = STATUS_ADDED;
		end
		// A weight of zero acts as one; anything above unity acts as unity.
		if (alpha_reg == 9'd0)
			weight = 1;
		else if (alpha_reg > EWMA_UNITY)
			weight = EWMA_UNITY;
		else
			weight = alpha_reg;
		gap = seqno - nbr_last_seq[slot];
		avg = gap * weight + (nbr_avg[slot] * (EWMA_UNITY - weight)) / EWMA_UNITY;
		if (avg > 32'hFFFF)
			avg = 32'hFFFF;
		nbr_avg[slot] = avg[15:0];
		nbr_last_seq[slot] = seqno;
		res.entry_index = slot[3:0];
		res.gap = gap;
		res.avg_gap = avg[15:0];
		return res;
	endfunction

	// Offer one beacon, wait for it to be taken, and record its result.
	task automatic send_beacon(input logic [15:0] addr, input logic [7:0] seqno,
			input logic [15:0] rssi, input logic [15:0] lqi, input bit typed,
			input ntge_result_t want);
		ntge_result_t predicted;
		while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {lqi, rssi, seqno, addr};
		do @(posedge clk); while (!s_tready);
		predicted = predict_link_update(addr, seqno);
		expected_results.push_back(typed ? want : predicted);
		beacons_sent++;
	endtask

	// Stop offering and wait until every pending result has come back.
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
	endtask

	// Weight register write; only issued while the block is idle.
	task automatic write_alpha(input logic [8:0] value);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		alpha_reg = value;
	endtask

	// Main sequence: reset, directed rows, then random phases.
	initial begin
		logic [15:0] addr;
		logic [7:0]  seqno;
		logic [15:0] rssi;
		logic [15:0] lqi;
		int unsigned slot;
		logic [8:0]  alpha_val;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		tx_idle_pct = 28;
		rx_idle_pct = 60;
		foreach (directed_rows[r])
			send_beacon(directed_rows[r].addr, directed_rows[r].seqno, directed_rows[r].rssi,
				directed_rows[r].lqi, directed_rows[r].typed, directed_rows[r].want);
		drain_results();

		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: alpha_val = 9'd256;
				1: alpha_val = 9'd1;
				2: alpha_val = 9'd0;
				3: alpha_val = 9'd511;
				4: alpha_val = 9'($urandom_range(255, 2));
				5: alpha_val = 9'($urandom_range(510, 257));
				default: alpha_val = ALPHA_RESET;
			endcase
			write_alpha(alpha_val);
			// Idling: sender light and receiver heavy, then swapped, then none.
			if (ph < 3) begin
				tx_idle_pct = 28;
				rx_idle_pct = 60;
			end else if (ph < 5) begin
				tx_idle_pct = 60;
				rx_idle_pct = 28;
			end else begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				// One pause in mid-stream until every result is back.
				if (ph == 5 && n == ITEMS_PER_PHASE / 2)
					drain_results();
				// Mostly well-formed beacons from known neighbors; the rest is noise.
				if (nbr_count != 0 && $urandom_range(99) < 85) begin
					slot = $urandom_range(nbr_count - 1);
					addr = nbr_addr[slot];
					case ($urandom_range(9))
						0, 1, 2, 3, 4, 5: seqno = nbr_last_seq[slot] + 8'd1;
						6, 7: seqno = nbr_last_seq[slot] + 8'($urandom_range(5));
						8: seqno = 8'($urandom);
						default: seqno = nbr_last_seq[slot] - 8'($urandom_range(1));
					endcase
				end else begin
					addr = 16'($urandom);
					seqno = 8'($urandom);
				end
				rssi = ($urandom_range(19) == 0) ? 16'hFFFF : 16'($urandom);
				lqi = ($urandom_range(19) == 0) ? 16'h0000 : 16'($urandom);
				send_beacon(addr, seqno, rssi, lqi, 1'b0, '0);
			end
			drain_results();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Covered %0d beacons: %0d added, %0d updated, %0d dropped on a full table.",
			beacons_sent, n_added, n_updated, n_dropped);
		$display("Weights 64, 256, 1, 0, 511 and two random values; one long output stall.");
		if (mismatches == 0 && expected_results.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// Receiver: random backpressure plus one long hold once enough results are in.
	always @(posedge clk) begin
		if (m_tvalid && m_tready)
			rx_taken++;
		if (hold_left != 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (rx_taken == 150 && !hold_done) begin
			hold_done = 1'b1;
			hold_left = 200;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// Compare every accepted result item with the oldest expectation.
	always @(posedge clk) begin : result_check
		ntge_result_t want;
		ntge_result_t seen;
		if (arst_n && m_tvalid && m_tready) begin
			seen.status = m_tdata[1:0];
			seen.entry_index = m_tdata[5:2];
			seen.gap = m_tdata[13:6];
			seen.avg_gap = m_tdata[29:14];
			if (expected_results.size() == 0) begin
				$error("result item with no beacon pending: %h", m_tdata);
				mismatches++;
			end else begin
				want = expected_results.pop_front();
				if (seen.status != want.status) begin
					$error("status: expected %0d, got %0d", want.status, seen.status);
					mismatches++;
				end
				if (seen.entry_index != want.entry_index) begin
					$error("entry_index: expected %0d, got %0d", want.entry_index,
						seen.entry_index);
					mismatches++;
				end
				if (seen.gap != want.gap) begin
					$error("gap: expected %0d, got %0d", want.gap, seen.gap);
					mismatches++;
				end
				if (seen.avg_gap != want.avg_gap) begin
					$error("avg_gap: expected %0d, got %0d", want.avg_gap, seen.avg_gap);
					mismatches++;
				end
				case (want.status)
					STATUS_ADDED: n_added++;
					STATUS_UPDATED: n_updated++;
					default: n_dropped++;
				endcase
			end
		end
	end

	// Watchdog: too long without any item moving ends the run.
	always @(posedge clk) begin
		if (!arst_n || cfg_wr_en || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles == STALL_LIMIT) begin
			$display("Watchdog: no item moved for %0d cycles.", STALL_LIMIT);
			$display("TEST FAILED");
			$finish;
		end
	end

endmodule
